// File: src/greedy_change_maker_defines.svh
// ----------------------------------------------------------------------------
// greedy_change_maker_defines.svh
// Assertion macros used by the checker file of the change maker.
// ----------------------------------------------------------------------------
`ifndef GREEDY_CHANGE_MAKER_DEFINES_SVH
`define GREEDY_CHANGE_MAKER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define GCM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("greedy_change_maker: check failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define GCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("greedy_change_maker: check failed");

`endif

// File: src/gcm_pkg.sv
// ----------------------------------------------------------------------------
// gcm_pkg
// Types, widths and reset values shared by the change maker modules.
// ----------------------------------------------------------------------------
package gcm_pkg;

  // Denomination registers and field widths.
  localparam int GCM_MAX_DENOMS = 7;
  localparam int AMOUNT_W       = 24;
  localparam int DENOM_W        = 16;
  localparam int IDX_W          = 3;
  localparam int CFG_IDX_W      = 4;
  localparam int STEP_W         = 5;
  localparam int OUT_TDATA_W    = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DENOM0 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DENOM6 = 4'd7;

  localparam logic [IDX_W-1:0] ACTIVE_RESET = 3'd7;

  typedef logic [DENOM_W-1:0] denom_t;

  // Reset values of the denomination registers, largest first.
  localparam denom_t DENOM_RESET [GCM_MAX_DENOMS] = '{
    16'd50000, 16'd10000, 16'd2000, 16'd500, 16'd100, 16'd10, 16'd1
  };

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_OUT
  } gcm_state_t;

  // Request to the shared divider.
  typedef struct packed {
    logic                start;
    logic [AMOUNT_W-1:0] dividend;
    denom_t              divisor;
  } div_req_t;

  // Answer from the shared divider.
  typedef struct packed {
    logic                done;
    logic [AMOUNT_W-1:0] quotient;
    denom_t              remainder;
  } div_rsp_t;

endpackage

// File: src/gcm_cfg.sv
// ----------------------------------------------------------------------------
// gcm_cfg
// Configuration registers: active denomination count and seven values.
// ----------------------------------------------------------------------------
module gcm_cfg
  import gcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  denom_t               cfg_wr_data,
  input  logic [IDX_W-1:0]     sel_idx,
  output denom_t               denom_sel,
  output logic [IDX_W-1:0]     n_active
);

  logic [IDX_W-1:0] active_r;
  denom_t           denom_r [GCM_MAX_DENOMS];

  // Register writes; indexes past the last denomination are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
      for (int i = 0; i < GCM_MAX_DENOMS; i++) begin
        denom_r[i] <= DENOM_RESET[i];
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_ACTIVE) begin
        active_r <= cfg_wr_data[IDX_W-1:0];
      end else if (cfg_index >= CFG_DENOM0 && cfg_index <= CFG_DENOM6) begin
        for (int i = 0; i < GCM_MAX_DENOMS; i++) begin
          if (cfg_index == CFG_DENOM0 + CFG_IDX_W'(i)) begin
            denom_r[i] <= cfg_wr_data;
          end
        end
      end
    end
  end

  // A count of zero runs one denomination; three bits cannot exceed seven.
  assign n_active  = (active_r == '0) ? IDX_W'(1) : active_r;
  assign denom_sel = denom_r[sel_idx];

endmodule

// File: src/gcm_div.sv
// ----------------------------------------------------------------------------
// gcm_div
// Shared restoring divider: 24-bit amount by 16-bit denomination, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module gcm_div
  import gcm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [AMOUNT_W-1:0] dq_r, dq_nxt;
  denom_t              part_r, part_nxt;
  denom_t              dvs_r, dvs_nxt;
  logic [DENOM_W+1:0]  diff;
  logic                qbit;

  // Trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    diff = {1'b0, part_r, dq_r[AMOUNT_W-1]} - {2'b00, dvs_r};
    qbit = ~diff[DENOM_W+1];
  end

  // Step control and data path.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    part_nxt = part_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_W'(AMOUNT_W - 1);
      dq_nxt   = req.dividend;
      part_nxt = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // Quotient bits shift in from the bottom as dividend bits leave the top.
      dq_nxt   = {dq_r[AMOUNT_W-2:0], qbit};
      part_nxt = qbit ? diff[DENOM_W-1:0] : {part_r[DENOM_W-2:0], dq_r[AMOUNT_W-1]};
      cnt_nxt  = cnt_r - STEP_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    dq_r   <= dq_nxt;
    part_r <= part_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dq_r;
  assign rsp.remainder = part_r;

endmodule

// File: src/greedy_change_maker.sv
// ----------------------------------------------------------------------------
// greedy_change_maker
// Greedy coin change: splits an amount over the active denominations in
// register order and emits one count per denomination.
//
//   Channel | Direction | Beat contents
//   --------+-----------+-----------------------------------------------
//   in_     | slave     | tdata[23:0] amount
//   out_    | master    | tdata[2:0] denom_index, tdata[26:3] unit_count,
//           |           | tlast = last, tuser[0] = failed
//   cfg_    | write     | cfg_index selects register, cfg_wr_data value
//
// Each denomination passes through a dispatch state, 24 divider steps, a load
// of the output register and the hand-off of the beat, which output stalls
// can extend; a zero denomination skips the divider.
// in_tready is high only while no amount is in progress.
// rst_n is synchronous and active low; it restores the reset register values.
// ----------------------------------------------------------------------------
module greedy_change_maker
  import gcm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Input beats
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [AMOUNT_W-1:0]    in_tdata,   // [23:0] amount
  // Result beats
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [2:0] denom_index, [26:3] unit_count
  output logic                   out_tlast,
  output logic                   out_tuser,  // [0] failed
  // Configuration writes
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DENOM_W-1:0]     cfg_wr_data
);

  gcm_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]    k_r, k_nxt;
  logic [AMOUNT_W-1:0] rem_r, rem_nxt;
  logic [IDX_W-1:0]    oidx_r, oidx_nxt;
  logic [AMOUNT_W-1:0] ocnt_r, ocnt_nxt;
  logic                olast_r, olast_nxt;
  logic                ofail_r, ofail_nxt;
  denom_t              denom_sel;
  logic [IDX_W-1:0]    n_active;
  logic                is_last;
  logic [AMOUNT_W-1:0] div_rem;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  gcm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .sel_idx     (k_r),
    .denom_sel   (denom_sel),
    .n_active    (n_active)
  );

  gcm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign is_last = (k_r == n_active - IDX_W'(1));
  assign div_rem = {{(AMOUNT_W-DENOM_W){1'b0}}, div_rsp.remainder};

  // Sequencer: one denomination at a time through the shared divider.
  always_comb begin
    state_nxt        = state_r;
    k_nxt            = k_r;
    rem_nxt          = rem_r;
    oidx_nxt         = oidx_r;
    ocnt_nxt         = ocnt_r;
    olast_nxt        = olast_r;
    ofail_nxt        = ofail_r;
    div_req.start    = 1'b0;
    div_req.dividend = rem_r;
    div_req.divisor  = denom_sel;
    in_tready        = 1'b0;
    out_tvalid       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          rem_nxt   = in_tdata;
          k_nxt     = '0;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (denom_sel == '0) begin
          // A zero denomination pays nothing and leaves the amount as is.
          oidx_nxt  = k_r;
          ocnt_nxt  = '0;
          olast_nxt = is_last;
          ofail_nxt = is_last && (rem_r != '0);
          state_nxt = ST_OUT;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          rem_nxt   = div_rem;
          oidx_nxt  = k_r;
          ocnt_nxt  = div_rsp.quotient;
          olast_nxt = is_last;
          ofail_nxt = is_last && (div_rem != '0);
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (olast_r) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = ST_START;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    rem_r   <= rem_nxt;
    oidx_r  <= oidx_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
    ofail_r <= ofail_nxt;
  end

  // Result beat from the output register.
  assign out_tdata = {{(OUT_TDATA_W-AMOUNT_W-IDX_W){1'b0}}, ocnt_r, oidx_r};
  assign out_tlast = olast_r;
  assign out_tuser = ofail_r;

endmodule

// File: src/gcm_checker.sv
// ----------------------------------------------------------------------------
// gcm_checker
// Port-level checks of the change maker, bound to the top level.
// ----------------------------------------------------------------------------
`include "greedy_change_maker_defines.svh"

module gcm_checker
  import gcm_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast,
  input logic                   out_tuser
);

  // Only one amount is in flight: no new beat is taken while a result waits.
  `GCM_ASSERT_NOW(a_no_overlap, out_tvalid, !in_tready)

  // Failure is only reported on the closing beat.
  `GCM_ASSERT_NOW(a_fail_on_last, out_tvalid && out_tuser, out_tlast)

  // More results owed after a non-final beat keep the input closed.
  `GCM_ASSERT_NEXT(a_busy_mid, out_tvalid && out_tready && !out_tlast, !in_tready)

  // The closing beat returns the block to taking amounts.
  `GCM_ASSERT_NEXT(a_idle_after_last, out_tvalid && out_tready && out_tlast, in_tready)

  // A stalled result beat holds.
  `GCM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind greedy_change_maker gcm_checker u_gcm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the greedy change maker. Amounts go in as beats on
// the in_ stream. A local model of the greedy split, kept in step with every
// register write, predicts the per-denomination counts. Each out_ beat is
// compared field by field with the oldest prediction. Directed amounts and
// register extremes come first. Random register settings with random amounts
// follow, then a long output hold-off and a final stretch with no idling.
// ----------------------------------------------------------------------------
module tb;
  import gcm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 600;
  localparam int SETTLE_CYCLES  = 200;

  // Register indexes that decode to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_DENOM6 + CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

  // One expected result beat.
  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic [AMOUNT_W-1:0] units;
    logic                last;
    logic                failed;
  } payout_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [AMOUNT_W-1:0]    in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DENOM_W-1:0]     cfg_wr_data = '0;

  // Shadow copy of the configuration registers.
  logic [IDX_W-1:0]       active_shadow = ACTIVE_RESET;
  logic [DENOM_W-1:0]     denom_shadow [GCM_MAX_DENOMS];

  payout_t pending_payouts [$];
  payout_t expected_beat;
  int      errors = 0;
  int      quiet_cycles = 0;
  bit      bursts_on = 1'b1;
  bit      hold_req = 1'b0;
  int      hold_left = 0;
  int      stall_left = 0;
  int      calm_left = 0;

  always #5 clk = ~clk;

  greedy_change_maker DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),     // [23:0] amount
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),    // [2:0] denom_index, [26:3] unit_count
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),    // [0] failed
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  // Greedy split of one amount over the active denominations in register
  // order; queues one expected beat per denomination.
  task automatic predict_payout(input logic [AMOUNT_W-1:0] amount);
    logic [AMOUNT_W-1:0] left;
    logic [AMOUNT_W-1:0] count;
    int                  n;
    payout_t             p;
    left = amount;
    n = (active_shadow == '0) ? 1 : int'(active_shadow);
    for (int k = 0; k < n; k++) begin
      count = '0;
      if (denom_shadow[k] != '0) begin
        count = left / denom_shadow[k];
        left  = left - count * denom_shadow[k];
      end
      p.idx    = k[IDX_W-1:0];
      p.units  = count;
      p.last   = (k == n - 1);
      p.failed = (k == n - 1) && (left != '0);
      pending_payouts = {pending_payouts, p};
    end
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch on %s: expected %0h, got %0h", field, want, got);
    errors++;
  endtask

  // One register write; the shadow follows at the same edge.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [DENOM_W-1:0] data);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    if (idx == CFG_ACTIVE)
      active_shadow = data[IDX_W-1:0];
    else if (idx >= CFG_DENOM0 && idx <= CFG_DENOM6)
      denom_shadow[idx - CFG_DENOM0] = data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Offers one amount, with an optional idle gap in front, and predicts its
  // results once the beat is taken.
  task automatic send_amount(input logic [AMOUNT_W-1:0] amount);
    int gap;
    gap = (bursts_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= amount;
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_payout(amount);
  endtask

  // Stops offering and lets every expected beat come out.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_payouts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [AMOUNT_W-1:0] random_amount();
    case ($urandom_range(0, 3))
      0:       return AMOUNT_W'($urandom);
      1:       return AMOUNT_W'($urandom_range(0, 65535));
      2:       return AMOUNT_W'($urandom_range(0, 999));
      default: return AMOUNT_W'(denom_shadow[$urandom_range(0, 6)] * $urandom_range(0, 255));
    endcase
  endfunction

  // Random active count with random upper data bits, and one of three
  // denomination styles: descending, descending down to a unit coin, or
  // arbitrary with one zero.
  task automatic load_random_config();
    logic [DENOM_W-1:0] d;
    int                 style;
    int                 zero_at;
    style   = $urandom_range(0, 2);
    zero_at = $urandom_range(0, GCM_MAX_DENOMS - 1);
    write_register(CFG_ACTIVE, DENOM_W'($urandom));
    d = DENOM_W'($urandom_range(1, 65535));
    for (int k = 0; k < GCM_MAX_DENOMS; k++) begin
      if (style == 2)
        d = (k == zero_at) ? '0 : DENOM_W'($urandom);
      else if (style == 1 && k == GCM_MAX_DENOMS - 1)
        d = DENOM_W'(1);
      write_register(CFG_DENOM0 + k[CFG_IDX_W-1:0], d);
      if (style != 2)
        d = DENOM_W'($urandom_range(1, d));
    end
  endtask

  task automatic test_reset_config();
    send_amount(24'd0);
    send_amount(24'd1);
    send_amount('1);
    send_amount(24'd88888);
    send_amount(24'd12345);
    send_amount(24'd49999);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    // Writes to undecoded indexes must change nothing.
    write_register(CFG_UNUSED_LO, 16'h1234);
    write_register(CFG_UNUSED_HI, 16'hFFFF);
    send_amount(24'd67891);
    wait_drained();
    // Only the low bits of the active count are kept; one coin of the
    // largest value.
    write_register(CFG_ACTIVE, 16'hFFF9);
    write_register(CFG_DENOM0, 16'hFFFF);
    send_amount('1);
    send_amount(24'd6553500);
    wait_drained();
    // An active count of zero acts as one.
    write_register(CFG_ACTIVE, 16'h0008);
    send_amount(24'd70000);
    wait_drained();
    // Not descending: a unit coin first takes everything.
    write_register(CFG_ACTIVE, 16'hFFFF);
    write_register(CFG_DENOM0, 16'd1);
    send_amount('1);
    send_amount(24'd0);
    wait_drained();
    // Zero denominations pay nothing and pass the remainder on.
    write_register(CFG_DENOM0, 16'd0);
    write_register(CFG_DENOM0 + 4'd1, 16'hFFFF);
    write_register(CFG_DENOM0 + 4'd2, 16'd0);
    write_register(CFG_DENOM0 + 4'd3, 16'd300);
    write_register(CFG_DENOM0 + 4'd4, 16'd7);
    write_register(CFG_DENOM0 + 4'd5, 16'd2);
    write_register(CFG_DENOM6, 16'd0);
    send_amount('1);
    send_amount(24'd299);
    send_amount(24'd196906);
    send_amount(24'd0);
    wait_drained();
    // Back to the reset coins with three active.
    for (int k = 0; k < GCM_MAX_DENOMS; k++)
      write_register(CFG_DENOM0 + k[CFG_IDX_W-1:0], DENOM_RESET[k]);
    write_register(CFG_ACTIVE, 16'd3);
    send_amount(24'd12345);
    send_amount(24'd60000);
    wait_drained();
  endtask

  task automatic test_random_configs();
    for (int phase = 0; phase < 6; phase++) begin
      load_random_config();
      repeat (30) send_amount(random_amount());
      wait_drained();
    end
  endtask

  // The receiver holds off while amounts keep coming, so the block fills up
  // and stalls its input.
  task automatic test_backpressure();
    write_register(CFG_ACTIVE, 16'd7);
    hold_req = 1'b1;
    repeat (6) send_amount(random_amount());
    wait_drained();
  endtask

  task automatic test_full_rate();
    bursts_on = 1'b0;
    repeat (30) send_amount(random_amount());
    wait_drained();
  endtask

  // Receiver: a long hold-off on request, random stall bursts, calm stretches.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left--;
      out_tready <= 1'b1;
    end else if (bursts_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(20, 80);
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare every accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_payouts.size() == 0) begin
        report_mismatch("unexpected beat", '0, out_tdata);
      end else begin
        expected_beat = pending_payouts.pop_front();
        if (out_tdata[IDX_W-1:0] !== expected_beat.idx)
          report_mismatch("denom_index", 32'(expected_beat.idx),
                          32'(out_tdata[IDX_W-1:0]));
        if (out_tdata[IDX_W+AMOUNT_W-1:IDX_W] !== expected_beat.units)
          report_mismatch("unit_count", 32'(expected_beat.units),
                          32'(out_tdata[IDX_W+AMOUNT_W-1:IDX_W]));
        if (out_tdata[OUT_TDATA_W-1:IDX_W+AMOUNT_W] !== '0)
          report_mismatch("tdata padding", '0,
                          32'(out_tdata[OUT_TDATA_W-1:IDX_W+AMOUNT_W]));
        if (out_tlast !== expected_beat.last)
          report_mismatch("last", 32'(expected_beat.last), 32'(out_tlast));
        if (out_tuser !== expected_beat.failed)
          report_mismatch("failed", 32'(expected_beat.failed), 32'(out_tuser));
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either stream.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    foreach (denom_shadow[k]) denom_shadow[k] = DENOM_RESET[k];
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_config();
    test_register_extremes();
    test_random_configs();
    test_backpressure();
    test_full_rate();
    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
